FILE: hdl/enveloped_sine_tone_generator_assert.svh
// Assertion macros for the enveloped sine tone generator.
// Used by modules that have aclk and aresetn in scope; needs no other file.
`ifndef ENVELOPED_SINE_TONE_GENERATOR_ASSERT_SVH
`define ENVELOPED_SINE_TONE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define ESTG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESTG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/estg_pkg.sv
// Shared types, constants and elaboration-time functions for the tone generator.
// No dependencies; used by every module of the block.
package estg_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 32;

    localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER_DEPTH = SINE_TABLE_DEPTH / 4;
    localparam int QUARTER_BITS  = SINE_IDX_BITS - 2;

    localparam int NOTE_LEN_W   = 16;
    localparam int GAIN_STEP_W  = 21;
    localparam int START_GAIN_W = 25;
    localparam int GAIN_W       = 32;
    localparam int STEP_W       = 32;
    localparam int SAMPLE_W     = 16;
    localparam int SINE_MAG_W   = 15;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 25;
    localparam int NUM_BOUNDS   = 6;

    localparam logic [NOTE_LEN_W-1:0]   NOTE_LENGTH_RST = 16'd20000;
    localparam logic [GAIN_STEP_W-1:0]  GAIN_STEP_RST   = 21'd78643;
    localparam logic [START_GAIN_W-1:0] START_GAIN_RST  = 25'd131072;

    localparam logic [CFG_ADDR_W-1:0] REG_NOTE_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_STEP   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_GAIN  = 2'd2;

    // floor(x / 7) = (x * DIV7_MUL) >> DIV7_SHIFT, exact for x below 2^19
    localparam logic [19:0] DIV7_MUL   = 20'd599187;
    localparam int          DIV7_SHIFT = 22;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [NUM_BOUNDS-1:0][NOTE_LEN_W-1:0] seg_bounds_t;
    typedef logic [SINE_MAG_W-1:0] quarter_rom_t [QUARTER_DEPTH];

    function automatic logic [NOTE_LEN_W-1:0] seg_bound(input logic [NOTE_LEN_W-1:0] len,
                                                       input logic [2:0] k);
        logic [18:0] scaled;
        logic [41:0] prod;
        scaled = 19'(len) * 19'(k);
        prod   = 42'(scaled) * 42'(DIV7_MUL);
        return prod[DIV7_SHIFT +: NOTE_LEN_W];
    endfunction

    function automatic seg_bounds_t all_bounds(input logic [NOTE_LEN_W-1:0] len);
        seg_bounds_t b;
        for (int k = 0; k < NUM_BOUNDS; k++) begin
            b[k] = seg_bound(len, 3'(k + 1));
        end
        return b;
    endfunction

    localparam seg_bounds_t BOUNDS_RST = all_bounds(NOTE_LENGTH_RST);

    // quarter-wave sine magnitude in Q0.15, Taylor series through x^13 in Q30
    function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned u);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          s;
        longint          v;
        x  = (longint'(4 * u) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(x);
        t  = ((t * x2) >> 30) / 6;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 20;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 42;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 72;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 110;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 156;
        s  = s + longint'(t);
        if (s < 0) begin
            s = 0;
        end
        v = (s * 32767 + (longint'(1) << 29)) >>> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return SINE_MAG_W'(v);
    endfunction

    function automatic quarter_rom_t build_quarter();
        quarter_rom_t r;
        for (int u = 0; u < QUARTER_DEPTH; u++) begin
            r[u] = sine_entry(u);
        end
        return r;
    endfunction

    localparam quarter_rom_t QUARTER_ROM = build_quarter();
    localparam logic [SINE_MAG_W-1:0] SINE_PEAK = sine_entry(QUARTER_DEPTH);

endpackage

FILE: hdl/enveloped_sine_tone_generator.sv
// Enveloped sine tone generator: one sample item out for each item in.
// An accepted item is held in the s1 registers, then in the output register that drives m_tvalid.
// Throughput: one item per cycle unless stalled, set by the phase/gain loop and one multiplier stage.
// Reset (aresetn low, synchronous): note restarts, pipeline empties, registers load defaults.
// Depends on estg_pkg, estg_sine_lookup, estg_env_step and the assertion header.
`include "enveloped_sine_tone_generator_assert.svh"

module enveloped_sine_tone_generator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [estg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [estg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [estg_pkg::STEP_W-1:0]           s_tdata,   // [31:0] phase_step
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [estg_pkg::SAMPLE_W-1:0]         m_tdata,   // [15:0] sample
    output logic                                  m_tlast
);

    localparam int PW = 2 * estg_pkg::GAIN_W - estg_pkg::SAMPLE_W;
    localparam int QW = PW - (estg_pkg::GAIN_W - 1);

    logic [estg_pkg::NOTE_LEN_W-1:0]     note_length_reg;
    logic [estg_pkg::GAIN_STEP_W-1:0]    gain_step_reg;
    logic [estg_pkg::START_GAIN_W-1:0]   start_gain_reg;
    estg_pkg::seg_bounds_t               bounds_reg;

    logic [estg_pkg::NOTE_LEN_W-1:0]     idx_reg, idx_next;
    logic signed [estg_pkg::GAIN_W-1:0]  gain_reg, gain_next;
    logic [estg_pkg::PHASE_BITS-1:0]     phase_reg, phase_next;
    logic [estg_pkg::STEP_W-1:0]         held_reg;

    logic                                s1_valid_reg, s1_valid_next;
    logic signed [estg_pkg::GAIN_W-1:0]  s1_gain_reg;
    logic signed [estg_pkg::SAMPLE_W-1:0] s1_sine_reg;
    logic                                s1_last_reg;

    logic                                out_valid_reg, out_valid_next;
    logic [estg_pkg::SAMPLE_W-1:0]       out_sample_reg, out_sample_next;
    logic                                out_last_reg;

    logic                                out_adv;
    logic                                acc;
    logic                                note_start;
    logic                                cur_last;
    logic signed [estg_pkg::GAIN_W-1:0]  eff_gain;
    logic [estg_pkg::PHASE_BITS-1:0]     eff_phase;
    logic [estg_pkg::STEP_W-1:0]         eff_step;
    logic signed [estg_pkg::SAMPLE_W-1:0] cur_sine;
    logic signed [estg_pkg::GAIN_W-1:0]  env_gain;

    logic signed [PW-1:0]                prod;
    logic [PW-1:0]                       mag;
    logic [QW-1:0]                       quot;

    // handshake
    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_adv;
    assign acc      = s_tvalid && s_tready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_length_reg <= estg_pkg::NOTE_LENGTH_RST;
            gain_step_reg   <= estg_pkg::GAIN_STEP_RST;
            start_gain_reg  <= estg_pkg::START_GAIN_RST;
            bounds_reg      <= estg_pkg::BOUNDS_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                estg_pkg::REG_NOTE_LENGTH: begin
                    note_length_reg <= cfg_wdata[estg_pkg::NOTE_LEN_W-1:0];
                    bounds_reg <= estg_pkg::all_bounds(cfg_wdata[estg_pkg::NOTE_LEN_W-1:0]);
                end
                estg_pkg::REG_GAIN_STEP: begin
                    gain_step_reg <= cfg_wdata[estg_pkg::GAIN_STEP_W-1:0];
                end
                estg_pkg::REG_START_GAIN: begin
                    start_gain_reg <= cfg_wdata[estg_pkg::START_GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // note state, with reload at note start
    assign note_start = (idx_reg == '0);
    assign eff_gain   = note_start ? signed'(estg_pkg::GAIN_W'(start_gain_reg)) : gain_reg;
    assign eff_phase  = note_start ? '0 : phase_reg;
    assign eff_step   = note_start ? s_tdata : held_reg;
    assign cur_last   = (idx_reg >= note_length_reg);

    estg_sine_lookup u_sine (
        .phase_idx (eff_phase[estg_pkg::PHASE_BITS-1 -: estg_pkg::SINE_IDX_BITS]),
        .sine      (cur_sine)
    );

    estg_env_step u_env (
        .gain      (eff_gain),
        .step      (gain_step_reg),
        .idx       (idx_reg),
        .bounds    (bounds_reg),
        .gain_next (env_gain)
    );

    always_comb begin
        idx_next   = idx_reg;
        gain_next  = gain_reg;
        phase_next = phase_reg;
        if (acc) begin
            if (cur_last) begin
                idx_next = '0;
            end else begin
                idx_next   = idx_reg + estg_pkg::NOTE_LEN_W'(1);
                gain_next  = env_gain;
                phase_next = eff_phase + estg_pkg::PHASE_BITS'(eff_step);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        gain_reg  <= gain_next;
        phase_reg <= phase_next;
        if (acc) begin
            held_reg    <= eff_step;
            s1_gain_reg <= eff_gain;
            s1_sine_reg <= cur_sine;
            s1_last_reg <= cur_last;
        end
    end

    // multiply, truncate toward zero, saturate
    assign prod = PW'(s1_gain_reg) * PW'(s1_sine_reg);
    assign mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
    assign quot = mag[PW-1 -: QW];

    always_comb begin
        if (prod[PW-1]) begin
            if (quot > QW'(32768)) begin
                out_sample_next = {1'b1, {(estg_pkg::SAMPLE_W-1){1'b0}}};
            end else begin
                out_sample_next = estg_pkg::SAMPLE_W'(QW'(0) - quot);
            end
        end else begin
            if (quot > QW'(32767)) begin
                out_sample_next = {1'b0, {(estg_pkg::SAMPLE_W-1){1'b1}}};
            end else begin
                out_sample_next = quot[estg_pkg::SAMPLE_W-1:0];
            end
        end
    end

    assign s1_valid_next  = s_tready ? acc : s1_valid_reg;
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            out_sample_reg <= out_sample_next;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tlast  = out_last_reg;

    `ESTG_ASSERT_NOW(stall_blocks_a, out_valid_reg && !m_tready && s1_valid_reg, !s_tready, "input taken into a full pipeline")
    `ESTG_ASSERT_NOW(empty_ready_a, !out_valid_reg, s_tready, "input refused with empty output")
    `ESTG_ASSERT_NEXT(note_wrap_a, acc && cur_last, idx_reg == '0, "note did not restart after last item")
    `ESTG_ASSERT_NEXT(note_count_a, acc && !cur_last, idx_reg == $past(idx_reg) + estg_pkg::NOTE_LEN_W'(1), "sample counter did not advance")
    `ESTG_ASSERT_NEXT(start_gain_a, acc && note_start, s1_gain_reg == signed'(estg_pkg::GAIN_W'($past(start_gain_reg))), "note start did not load start gain")

endmodule

FILE: hdl/estg_sine_lookup.sv
// Sine lookup: maps the top phase bits onto a quarter-wave table.
// Depends on estg_pkg for the table and widths.
module estg_sine_lookup (
    input  logic [estg_pkg::SINE_IDX_BITS-1:0] phase_idx,
    output logic signed [estg_pkg::SAMPLE_W-1:0] sine
);

    logic [1:0]                              quad;
    logic [estg_pkg::QUARTER_BITS-1:0]       rem;
    logic [estg_pkg::SINE_MAG_W-1:0]         mag;
    logic signed [estg_pkg::SAMPLE_W-1:0]    mag_s;

    assign quad = phase_idx[estg_pkg::SINE_IDX_BITS-1 -: 2];
    assign rem  = phase_idx[estg_pkg::QUARTER_BITS-1:0];

    always_comb begin
        if (quad[0]) begin
            if (rem == '0) begin
                mag = estg_pkg::SINE_PEAK;
            end else begin
                mag = estg_pkg::QUARTER_ROM[estg_pkg::QUARTER_BITS'('0) - rem];
            end
        end else begin
            mag = estg_pkg::QUARTER_ROM[rem];
        end
    end

    assign mag_s = signed'({1'b0, mag});
    assign sine  = quad[1] ? -mag_s : mag_s;

endmodule

FILE: hdl/estg_env_step.sv
// Envelope update: picks one of seven segments and saturates the new gain.
// Depends on estg_pkg for the bound type and widths.
module estg_env_step (
    input  logic signed [estg_pkg::GAIN_W-1:0]      gain,
    input  logic [estg_pkg::GAIN_STEP_W-1:0]        step,
    input  logic [estg_pkg::NOTE_LEN_W-1:0]         idx,
    input  estg_pkg::seg_bounds_t                   bounds,
    output logic signed [estg_pkg::GAIN_W-1:0]      gain_next
);

    localparam int DW = estg_pkg::GAIN_STEP_W + 2;
    localparam int SW = estg_pkg::GAIN_W + 2;

    logic signed [DW-1:0] step_s;
    logic signed [DW-1:0] half_s;
    logic signed [DW-1:0] quarter_s;
    logic signed [DW-1:0] delta;
    logic                 halve;
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] sum;

    assign step_s    = signed'({2'b00, step});
    assign half_s    = signed'({3'b000, step[estg_pkg::GAIN_STEP_W-1:1]});
    assign quarter_s = signed'({4'b0000, step[estg_pkg::GAIN_STEP_W-1:2]});

    always_comb begin
        halve = 1'b0;
        if (idx <= bounds[0]) begin
            delta = step_s;
        end else if (idx <= bounds[1]) begin
            delta = -half_s;
        end else if (idx <= bounds[2]) begin
            delta = '0;
        end else if (idx <= bounds[3]) begin
            delta = -quarter_s;
        end else if (idx <= bounds[4]) begin
            delta = '0;
        end else if (idx <= bounds[5]) begin
            delta = -half_s;
        end else begin
            delta = step_s;
            halve = 1'b1;
        end
    end

    assign base = halve ? SW'(gain >>> 1) : SW'(gain);
    assign sum  = base + SW'(delta);

    always_comb begin
        if (sum[SW-1:estg_pkg::GAIN_W-1] == '0 || sum[SW-1:estg_pkg::GAIN_W-1] == '1) begin
            gain_next = sum[estg_pkg::GAIN_W-1:0];
        end else if (sum[SW-1]) begin
            gain_next = {1'b1, {(estg_pkg::GAIN_W-1){1'b0}}};
        end else begin
            gain_next = {1'b0, {(estg_pkg::GAIN_W-1){1'b1}}};
        end
    end

endmodule
